// ===== sv/sha256_pkg.sv =====
// sha256_pkg: shared types and constants for the sha-256 byte stream hasher
// no dependencies
package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        digest_last;
   } rsp_type;

   // classified item between front and back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } cmd_type;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== sv/sha256_fifo.sv =====
// sha256_fifo: small register queue between the front and back parts
// uses sha256_pkg::cmd_type
module sha256_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  sha256_pkg::cmd_type  wr_data,
   output logic                 full,
   input  logic                 rd_en,
   output sha256_pkg::cmd_type  rd_data,
   output logic                 empty
);
   localparam int AW = $clog2(DEPTH);

   sha256_pkg::cmd_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (wr_en) begin
         wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (rd_en) begin
         rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (wr_en) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end
endmodule

// ===== sv/sha256_core.sv =====
// sha256_core: back part; block buffer, padding, 64-round compression, digest output
// uses sha256_pkg for types, round constants and initial hash values
module sha256_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  sha256_pkg::cmd_type  cmd,
   output logic                 cmd_take,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output sha256_pkg::rsp_type  rsp_data
);
   localparam logic [2:0] ST_ABSORB = 3'd0;
   localparam logic [2:0] ST_ROUND  = 3'd1;
   localparam logic [2:0] ST_ADD    = 3'd2;
   localparam logic [2:0] ST_PAD    = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [60:0] len_ff, len_in;
   logic        fin_ff, fin_in;    // end mark seen for the message being compressed
   logic        last_ff, last_in;  // this block carries the length
   logic [2:0]  out_ff, out_in;
   // set once the pad byte has been placed in a block of this message
   logic        fin_pad_ff, fin_pad_in;

   logic [7:0]  blk [64];
   logic [7:0]  nbyte;
   logic [31:0] s0, s1, wnew, t1, t2;
   logic [63:0] bitlen;

   // w_ff viewed as bytes, read when the padding step rewrites the block
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         for (int j = 0; j < 4; j++) begin
            blk[4*i+j] = w_ff[i][31-8*j -: 8];
         end
      end
   end

   assign bitlen = {len_ff, 3'b000};
   assign s0 = sha256_pkg::rotr(w_ff[1], 7) ^ sha256_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1 = sha256_pkg::rotr(w_ff[14], 17) ^ sha256_pkg::rotr(w_ff[14], 19)
             ^ (w_ff[14] >> 10);
   assign wnew = s1 + w_ff[9] + s0 + w_ff[0];
   assign t1 = v_ff[7]
             + (sha256_pkg::rotr(v_ff[4], 6) ^ sha256_pkg::rotr(v_ff[4], 11)
                ^ sha256_pkg::rotr(v_ff[4], 25))
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + sha256_pkg::round_k(rnd_ff) + w_ff[0];
   assign t2 = (sha256_pkg::rotr(v_ff[0], 2) ^ sha256_pkg::rotr(v_ff[0], 13)
                ^ sha256_pkg::rotr(v_ff[0], 22))
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   assign cmd_take  = (state_ff == ST_ABSORB) && cmd_valid;
   assign rsp_empty = (state_ff != ST_EMIT);
   assign rsp_data.digest_word = h_ff[out_ff];
   assign rsp_data.digest_last = (out_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      v_in     = v_ff;
      fill_in  = fill_ff;
      rnd_in   = rnd_ff;
      len_in   = len_ff;
      fin_in   = fin_ff;
      last_in  = last_ff;
      out_in   = out_ff;
      nbyte    = '0;
      unique case (state_ff)
         ST_ABSORB: begin
            if (cmd_valid) begin
               if (cmd.has_byte) begin
                  w_in[fill_ff[5:2]][31-8*fill_ff[1:0] -: 8] = cmd.data_byte;
                  fill_in = fill_ff + 1'b1;
                  len_in  = len_ff + 1'b1;
               end
               fin_in = cmd.end_of_message;
               if (cmd.has_byte && fill_ff == 6'd63) begin
                  last_in  = 1'b0;
                  v_in     = h_ff;
                  rnd_in   = '0;
                  state_in = ST_ROUND;
               end else if (cmd.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // pad byte then zeros from fill position; length if it fits
            for (int b = 0; b < 64; b++) begin
               if (b[5:0] == fill_ff) begin
                  nbyte = sha256_pkg::PAD_BYTE;
               end else if (b[5:0] > fill_ff) begin
                  nbyte = 8'h00;
               end else begin
                  nbyte = blk[b];
               end
               if (fill_ff < sha256_pkg::LEN_POS && b >= 56) begin
                  nbyte = bitlen[63-8*(b-56) -: 8];
               end
               w_in[b/4][31-8*(b%4) -: 8] = nbyte;
            end
            last_in  = (fill_ff < sha256_pkg::LEN_POS);
            fin_in   = 1'b1;
            v_in     = h_ff;
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = wnew;
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            if (!fin_ff) begin
               state_in = ST_ABSORB;
            end else if (last_ff) begin
               out_in   = '0;
               state_in = ST_EMIT;
            end else begin
               // second padding block: zeros and length, led by the pad byte if not yet placed
               for (int i = 0; i < 14; i++) begin
                  w_in[i] = '0;
               end
               w_in[14] = bitlen[63:32];
               w_in[15] = bitlen[31:0];
               // full block with end mark: pad byte leads
               if (fill_ff == '0 && !fin_pad_ff) begin
                  w_in[0] = {sha256_pkg::PAD_BYTE, 24'h0};
               end
               last_in  = 1'b1;
               v_in     = h_in;
               rnd_in   = '0;
               state_in = ST_ROUND;
            end
         end
         ST_EMIT: begin
            if (rsp_pop) begin
               out_in = out_ff + 1'b1;
               if (out_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) begin
                     h_in[i] = sha256_pkg::INIT_H[i];
                  end
                  fill_in  = '0;
                  len_in   = '0;
                  fin_in   = 1'b0;
                  state_in = ST_ABSORB;
               end
            end
         end
         default: state_in = ST_ABSORB;
      endcase
   end

   always_comb begin
      fin_pad_in = fin_pad_ff;
      if (state_ff == ST_PAD) begin
         fin_pad_in = 1'b1;
      end else if (state_ff == ST_EMIT) begin
         fin_pad_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_ABSORB;
         fill_ff    <= '0;
         len_ff     <= '0;
         fin_ff     <= 1'b0;
         fin_pad_ff <= 1'b0;
         last_ff    <= 1'b0;
         rnd_ff     <= '0;
         out_ff     <= '0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sha256_pkg::INIT_H[i];
         end
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         len_ff     <= len_in;
         fin_ff     <= fin_in;
         fin_pad_ff <= fin_pad_in;
         last_ff    <= last_in;
         rnd_ff     <= rnd_in;
         out_ff     <= out_in;
         h_ff       <= h_in;
      end
      w_ff <= w_in;
      v_ff <= v_in;
   end
endmodule

// ===== sv/sha256_byte_stream_hasher.sv =====
// sha256_byte_stream_hasher: top level; front queue feeding the compression back end
// uses sha256_pkg, sha256_fifo, sha256_core
//
//  channel  ports                      beat
//  req      req_push, req_full, req    one message byte and/or end mark
//  rsp      rsp_empty, rsp_pop, rsp    one 32-bit digest word, H0 first
//
// the back end takes a byte only while absorbing; a full block is then compressed
// one round per cycle on a single round unit, followed by the chaining add
// an end mark adds a padding step (none when its byte completes a block)
// plus one or two blocks, then 8 digest beats
// the front queue keeps accepting up to QUEUE_DEPTH beats while the back end compresses
// synchronous active-high reset restores the initial hash values and empties the queue
module sha256_byte_stream_hasher #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  sha256_pkg::req_type req,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output sha256_pkg::rsp_type rsp
);
   sha256_pkg::cmd_type q_wr, q_rd;
   logic q_empty, q_take;

   // front: classify beat into a queued command
   assign q_wr.data_byte      = req.has_byte ? req.data_byte : 8'h00;
   assign q_wr.has_byte       = req.has_byte;
   assign q_wr.end_of_message = req.end_of_message;

   sha256_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_push && !req_full),
      .wr_data (q_wr),
      .full    (req_full),
      .rd_en   (q_take),
      .rd_data (q_rd),
      .empty   (q_empty)
   );

   // back: block buffer, rounds and digest output
   sha256_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (q_rd),
      .cmd_take  (q_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp)
   );
endmodule
